// File: sv/edge_neg_log_prob_cost_top_defines.svh
// Assertion macros used by the edge cost datapath
`ifndef EDGE_NEG_LOG_PROB_COST_TOP_DEFINES_SVH
`define EDGE_NEG_LOG_PROB_COST_TOP_DEFINES_SVH

// same-cycle implication
`define ENLPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("enlpc assertion failed");

// next-cycle implication
`define ENLPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("enlpc assertion failed");

`endif

// File: sv/enlpc_pkg.sv
// ----------------------------------------------------------------------------
// enlpc_pkg
// Types and constants of the edge cost block.
// ----------------------------------------------------------------------------
package enlpc_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam logic [7:0] FORBIDDEN_CLASS = 8'd2;
    localparam logic [7:0] OFFMAP_CLASS = 8'd255;
    localparam logic [22:0] COST_MAX = 23'd6553600;
    localparam logic [31:0] CLAMP_TERM = 32'd120722;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    // ceil(2^24 / 5): exact divide by five for dividends below 2^22
    localparam logic [21:0] RECIP5_Q24 = 22'h333334;
    localparam logic [15:0] PROB_CLAMP_MAX = 16'd6;
    localparam logic [4:0] SQ_LAST = 5'd23;
    localparam logic [23:0] RES_RESET = 24'd65536;
    localparam logic [16:0] FRAC_RESET = 17'd32768;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 40;

    localparam logic REG_MAP_RES = 1'b0;
    localparam logic REG_MAX_FRAC = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQR,
        ST_LMUL,
        ST_LRECIP,
        ST_APPLY,
        ST_DECIDE,
        ST_CSTART,
        ST_CDIV,
        ST_EMIT
    } enlpc_state_t;

    typedef struct packed {
        logic load;
        logic sqr_step;
        logic lmul;
        logic lrecip;
        logic div_start;
        logic apply;
        logic decide;
        logic emit;
    } enlpc_cmd_t;

    typedef struct packed {
        logic in_empty;
        logic in_needs_log;
        logic sqr_last;
        logic div_done;
        logic last_reg;
        logic blocked_reg;
        logic out_busy;
    } enlpc_status_t;

endpackage

// File: sv/edge_neg_log_prob_cost_top.sv
// ----------------------------------------------------------------------------
// edge_neg_log_prob_cost_top
// Edge cost from streamed map samples (negative log traversal probability).
// ----------------------------------------------------------------------------
// Input channel s_*: one map sample per transfer; s_last_sample closes an edge,
// s_empty_edge reports an edge without samples (result is blocked).
// Output channel m_*: one result per edge, blocked flag and Q7.16 cost.
// Config port cfg_*: index 0 map resolution, index 1 off-map fraction limit;
// write only while idle.
// Sequence: a sample with probability above 6 and a usable class is accepted,
// then passes the 24 squaring steps of the log2 unit, the ln2 multiply, the
// reciprocal divide by five and the accumulate. Other samples go from accept
// straight to the accumulate. The last sample of an edge adds the off-map
// test and the 64-step radix-2 cost division, or only the off-map test when
// the edge is blocked. An empty edge mark goes from accept to the emit state.
// The result sits in an output register; the next sample is taken while it
// waits. If the receiver stalls, a following edge result waits in the
// emit state and no new sample is taken until the transfer completes.
// Reset: accumulators clear, resolution becomes 1.0, fraction limit 0.5.
// ----------------------------------------------------------------------------
module edge_neg_log_prob_cost_top
    import enlpc_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_terrain_class,
    input  logic [15:0] s_prob,
    input  logic        s_last_sample,
    input  logic        s_empty_edge,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_blocked,
    output logic [22:0] m_edge_cost
);

    enlpc_cmd_t    cmd;
    enlpc_status_t status;

    enlpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    enlpc_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_terrain_class (s_terrain_class),
        .s_prob          (s_prob),
        .s_last_sample   (s_last_sample),
        .s_empty_edge    (s_empty_edge),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_blocked       (m_blocked),
        .m_edge_cost     (m_edge_cost)
    );

endmodule

// File: sv/enlpc_div.sv
// ----------------------------------------------------------------------------
// enlpc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module enlpc_div
    import enlpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic [DIV_NUM_W-1:0] quot,
    output logic                 done
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] q_reg, q_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 ge;

    always_comb begin
        rem_sh    = {rem_reg, q_reg[DIV_NUM_W-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = num;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = {q_reg[DIV_NUM_W-2:0], ge};
            rem_next = ge ? DIV_DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

// File: sv/enlpc_datapath.sv
// ----------------------------------------------------------------------------
// enlpc_datapath
// Config and sample registers, log2 squaring unit, accumulators, cost divider, output.
// ----------------------------------------------------------------------------
`include "edge_neg_log_prob_cost_top_defines.svh"

module enlpc_datapath
    import enlpc_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  enlpc_cmd_t    cmd,
    output enlpc_status_t status,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [23:0]   cfg_wdata,
    input  logic [7:0]    s_terrain_class,
    input  logic [15:0]   s_prob,
    input  logic          s_last_sample,
    input  logic          s_empty_edge,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_blocked,
    output logic [22:0]   m_edge_cost
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

    logic [23:0] res_reg;
    logic [16:0] frac_lim_reg;

    logic [7:0]  cls_reg;
    logic [15:0] p_reg;
    logic        last_reg;

    logic [3:0]  e_reg;
    logic [31:0] m_reg;
    logic [23:0] fr_reg;
    logic [4:0]  sq_cnt_reg;
    logic [63:0] lprod_reg;
    logic [31:0] lterm_reg;

    logic [31:0]      sum_reg;
    logic [CNT_W-1:0] vcnt_reg, icnt_reg, ocnt_reg;
    logic             abort_reg;
    logic             blocked_reg;

    logic        out_valid_reg;
    logic        out_blocked_reg;
    logic [22:0] out_cost_reg;

    logic [3:0]           e_in;
    logic [63:0]          sq_prod;
    logic [32:0]          sq;
    logic [28:0]          n_val;
    logic [45:0]          lq_prod;
    logic [DIV_NUM_W-1:0] div_num, div_quot;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [32:0]          sum_add;
    logic [31:0]          term;
    logic [CNT_W:0]       total;
    logic [63:0]          lhs, rhs;
    logic [23:0]          res_nz;
    logic                 out_busy;
    logic [22:0]          cost_clamped;

    // msb index of the probability
    always_comb begin
        e_in = '0;
        for (int i = 1; i < 16; i++) begin
            if (s_prob[i]) begin
                e_in = 4'(i);
            end
        end
    end

    assign sq_prod = 64'(m_reg) * 64'(m_reg);
    assign sq      = sq_prod[63:31];
    assign n_val   = 29'(29'd1 << 28) - 29'({e_reg, fr_reg});

    // (lprod >> 40) / 5 by reciprocal multiply; dividend stays below 2^20
    assign lq_prod = 46'(lprod_reg[63:40]) * 46'(RECIP5_Q24);

    assign res_nz = (res_reg == '0) ? 24'd1 : res_reg;
    always_comb begin
        if (vcnt_reg == '0) begin
            div_num = 64'(64'd1 << 32) + 64'(res_nz) * 64'd500;
            div_den = DIV_DEN_W'(40'(res_nz) * 40'd1000);
        end else begin
            div_num = 64'(sum_reg) * 64'(res_reg) + (64'(vcnt_reg) << 15);
            div_den = DIV_DEN_W'(40'(vcnt_reg) << 16);
        end
    end

    enlpc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_quot),
        .done    (div_done)
    );

    assign term    = (p_reg <= PROB_CLAMP_MAX) ? CLAMP_TERM : lterm_reg;
    assign sum_add = 33'(sum_reg) + 33'(term);
    assign total   = (CNT_W+1)'(vcnt_reg) + (CNT_W+1)'(icnt_reg);
    assign lhs     = 64'(ocnt_reg) << 16;
    assign rhs     = 64'(frac_lim_reg) * 64'(total);

    assign cost_clamped = (div_quot > 64'(COST_MAX)) ? COST_MAX : div_quot[22:0];
    assign out_busy     = out_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg       <= RES_RESET;
            frac_lim_reg  <= FRAC_RESET;
            sum_reg       <= '0;
            vcnt_reg      <= '0;
            icnt_reg      <= '0;
            ocnt_reg      <= '0;
            abort_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MAP_RES:  res_reg <= cfg_wdata;
                    REG_MAX_FRAC: frac_lim_reg <= cfg_wdata[16:0];
                    default:      ;
                endcase
            end
            if (cmd.apply && !abort_reg) begin
                if (cls_reg == FORBIDDEN_CLASS) begin
                    abort_reg <= 1'b1;
                end else begin
                    if (p_reg != '0) begin
                        sum_reg <= sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
                        if (vcnt_reg < CNT_MAX) vcnt_reg <= vcnt_reg + 1'b1;
                    end else begin
                        if (icnt_reg < CNT_MAX) icnt_reg <= icnt_reg + 1'b1;
                    end
                    if (cls_reg == OFFMAP_CLASS && ocnt_reg < CNT_MAX) begin
                        ocnt_reg <= ocnt_reg + 1'b1;
                    end
                end
            end
            if (cmd.emit && !out_busy) begin
                out_valid_reg <= 1'b1;
                sum_reg       <= '0;
                vcnt_reg      <= '0;
                icnt_reg      <= '0;
                ocnt_reg      <= '0;
                abort_reg     <= 1'b0;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cls_reg     <= s_terrain_class;
            p_reg       <= s_prob;
            last_reg    <= s_last_sample;
            blocked_reg <= 1'b1;
            e_reg       <= e_in;
            m_reg       <= 32'(s_prob) << (5'd31 - 5'(e_in));
            fr_reg      <= '0;
            sq_cnt_reg  <= '0;
        end
        if (cmd.sqr_step) begin
            m_reg      <= sq[32] ? sq[32:1] : sq[31:0];
            fr_reg     <= {fr_reg[22:0], sq[32]};
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
        end
        if (cmd.lmul) begin
            lprod_reg <= 64'(n_val) * 64'(LN2_Q32) + (64'd5 << 39);
        end
        if (cmd.lrecip) begin
            lterm_reg <= 32'(lq_prod[45:24]);
        end
        if (cmd.decide) begin
            blocked_reg <= abort_reg || (total == '0) || (lhs > rhs);
        end
        if (cmd.emit && !out_busy) begin
            out_blocked_reg <= blocked_reg;
            out_cost_reg    <= blocked_reg ? 23'd0 : cost_clamped;
        end
    end

    always_comb begin
        status.in_empty     = s_empty_edge;
        status.in_needs_log = !abort_reg && (s_terrain_class != FORBIDDEN_CLASS)
                              && (s_prob > PROB_CLAMP_MAX);
        status.sqr_last     = (sq_cnt_reg == SQ_LAST);
        status.div_done     = div_done;
        status.last_reg     = last_reg;
        status.blocked_reg  = blocked_reg;
        status.out_busy     = out_busy;
    end

    assign m_valid     = out_valid_reg;
    assign m_blocked   = out_blocked_reg;
    assign m_edge_cost = out_cost_reg;

    `ENLPC_ASSERT_IMP(a_cnt_sat, aclk, aresetn, 1'b1, vcnt_reg <= CNT_MAX && icnt_reg <= CNT_MAX)
    `ENLPC_ASSERT_IMP(a_blk_zero, aclk, aresetn, out_valid_reg && out_blocked_reg, out_cost_reg == '0)
    `ENLPC_ASSERT_NXT(a_emit_clr, aclk, aresetn, cmd.emit && !out_busy, sum_reg == '0 && !abort_reg)

endmodule

// File: sv/enlpc_ctrl.sv
// ----------------------------------------------------------------------------
// enlpc_ctrl
// Sequencer for per-sample log term, accumulation and edge cost.
// ----------------------------------------------------------------------------
module enlpc_ctrl
    import enlpc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  enlpc_status_t status,
    output enlpc_cmd_t    cmd
);

    enlpc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (status.in_empty) state_next = ST_EMIT;
                    else if (status.in_needs_log) state_next = ST_SQR;
                    else state_next = ST_APPLY;
                end
            end
            ST_SQR: begin
                cmd.sqr_step = 1'b1;
                if (status.sqr_last) state_next = ST_LMUL;
            end
            ST_LMUL: begin
                cmd.lmul   = 1'b1;
                state_next = ST_LRECIP;
            end
            ST_LRECIP: begin
                cmd.lrecip = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = status.last_reg ? ST_DECIDE : ST_IDLE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_CSTART;
            end
            ST_CSTART: begin
                if (status.blocked_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_CDIV;
                end
            end
            ST_CDIV: begin
                if (status.div_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                cmd.emit = 1'b1;
                if (!status.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: tb/sv/edge_neg_log_prob_cost_checker.sv
// ----------------------------------------------------------------------------
// edge_neg_log_prob_cost_checker
// Watches the sample, result and register ports of the edge cost block,
// predicts each edge result and compares it with what the block delivers.
// ----------------------------------------------------------------------------
module edge_neg_log_prob_cost_checker
    import enlpc_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_terrain_class,
    input  logic [15:0] s_prob,
    input  logic        s_last_sample,
    input  logic        s_empty_edge,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_blocked,
    input  logic [22:0] m_edge_cost,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = $clog2(MAX_SAMPLES + 1);

    typedef struct {
        logic        blocked;
        logic [22:0] cost;
    } edge_result_t;

    edge_result_t edge_result_q[$];

    logic [23:0]   res_q16;
    logic [16:0]   frac_limit;
    logic [31:0]   log_sum;
    logic [CW-1:0] n_valid;
    logic [CW-1:0] n_invalid;
    logic [CW-1:0] n_offmap;
    logic          aborted;

    // -ln(max(p,1e-4))/5 in Q16, log2 by repeated squaring
    function automatic logic [31:0] neg_log_q16(input logic [15:0] p);
        logic [4:0]  e;
        logic [63:0] m;
        logic [23:0] frac;
        logic [63:0] n;
        e = 0;
        frac = 0;
        if (p <= PROB_CLAMP_MAX) return CLAMP_TERM;
        while (e < 15 && ({16'd0, p} >> (e + 1)) != 0) e++;
        m = 64'(p) << (31 - e);
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        n = (64'd16 << 24) - ((64'(e) << 24) | 64'(frac));
        return 32'((n * 64'(LN2_Q32) + 64'd5 * (64'd1 << 39)) / (64'd5 * (64'd1 << 40)));
    endfunction

    function automatic logic [22:0] edge_cost_q16();
        logic [63:0] r;
        logic [63:0] c;
        logic [63:0] d;
        r = 64'(res_q16);
        if (n_valid == 0) begin
            if (r == 0) r = 1;
            c = ((64'd1 << 32) + 64'd500 * r) / (64'd1000 * r);
        end else begin
            d = 64'(n_valid) * 64'd65536;
            c = (64'(log_sum) * r + d / 2) / d;
        end
        return (c > 64'(COST_MAX)) ? COST_MAX : 23'(c);
    endfunction

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        return (c < MAX_SAMPLES) ? c + 1'b1 : c;
    endfunction

    task automatic clear_edge();
        log_sum = 0;
        n_valid = 0;
        n_invalid = 0;
        n_offmap = 0;
        aborted = 1'b0;
    endtask

    task automatic predict_sample(input logic [7:0] cls, input logic [15:0] p,
                                  input logic last, input logic empty);
        logic [32:0]  s;
        logic [CW:0]  total;
        logic         blk;
        edge_result_t r;
        if (empty) begin
            clear_edge();
            r.blocked = 1'b1;
            r.cost = '0;
            edge_result_q = {edge_result_q, r};
            return;
        end
        if (!aborted) begin
            if (cls == FORBIDDEN_CLASS) begin
                aborted = 1'b1;
            end else begin
                if (p != 0) begin
                    s = 33'(log_sum) + 33'(neg_log_q16(p));
                    log_sum = s[32] ? 32'hFFFF_FFFF : s[31:0];
                    n_valid = sat_inc(n_valid);
                end else begin
                    n_invalid = sat_inc(n_invalid);
                end
                if (cls == OFFMAP_CLASS) n_offmap = sat_inc(n_offmap);
            end
        end
        if (!last) return;
        total = (CW+1)'(n_valid) + (CW+1)'(n_invalid);
        blk = aborted || total == 0 ||
              (64'(n_offmap) * 64'd65536 > 64'(frac_limit) * 64'(total));
        r.blocked = blk;
        r.cost = blk ? 23'd0 : edge_cost_q16();
        edge_result_q = {edge_result_q, r};
        clear_edge();
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("ERROR t=%0t %s: got %0d expected %0d", $time, what, got, exp);
        errors++;
    endtask

    always @(posedge aclk) begin
        edge_result_t r;
        if (!aresetn) begin
            errors = 0;
            res_q16 = RES_RESET;
            frac_limit = FRAC_RESET;
            clear_edge();
            edge_result_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_MAP_RES) res_q16 = cfg_wdata;
                else frac_limit = cfg_wdata[16:0];
            end
            if (s_valid && s_ready)
                predict_sample(s_terrain_class, s_prob, s_last_sample, s_empty_edge);
            if (m_valid && m_ready) begin
                if (edge_result_q.size() == 0) begin
                    report("unexpected result", 32'(m_edge_cost), 32'd0);
                end else begin
                    r = edge_result_q.pop_front();
                    if (m_blocked !== r.blocked)
                        report("blocked", 32'(m_blocked), 32'(r.blocked));
                    if (m_edge_cost !== r.cost)
                        report("edge_cost", 32'(m_edge_cost), 32'(r.cost));
                end
            end
        end
        pending = edge_result_q.size();
    end

endmodule

// File: tb/sv/tb_edge_neg_log_prob_cost_top.sv
// ----------------------------------------------------------------------------
// tb_edge_neg_log_prob_cost_top
// Drives directed and random edges through the edge cost block over several
// register settings, with random idling on the sample channel and back pressure on the result channel.
// ----------------------------------------------------------------------------
module tb_edge_neg_log_prob_cost_top;
    import enlpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 300;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [23:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_terrain_class;
    logic [15:0] s_prob;
    logic        s_last_sample;
    logic        s_empty_edge;
    logic        m_valid;
    logic        m_ready;
    logic        m_blocked;
    logic [22:0] m_edge_cost;
    int          errors;
    int          pending;
    logic        hold_req;
    int          hold_left;
    bit          no_gaps;

    edge_neg_log_prob_cost_top i_dut (.*);

    edge_neg_log_prob_cost_checker i_chk (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("edge_neg_log_prob_cost_top: mismatch");
        $finish;
    end

    function automatic int rand_gap();
        if (no_gaps || $urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_req) begin
            m_ready <= 1'b0;
            hold_left <= 4000;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (no_gaps) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 3) == 0);
        end
    end

    task automatic send(input logic [7:0] cls, input logic [15:0] p,
                        input logic last, input logic empty);
        int gap;
        s_valid <= 1'b1;
        s_terrain_class <= cls;
        s_prob <= p;
        s_last_sample <= last;
        s_empty_edge <= empty;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        gap = rand_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] rand_class();
        int k;
        k = $urandom_range(0, 99);
        if (k < 3) return FORBIDDEN_CLASS;
        if (k < 15) return OFFMAP_CLASS;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] rand_prob();
        int k;
        k = $urandom_range(0, 99);
        if (k < 15) return 16'd0;
        if (k < 30) return 16'($urandom_range(1, 8));
        if (k < 35) return 16'hFFFF;
        return 16'($urandom());
    endfunction

    task automatic rand_edge(output int n);
        int len;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
        n = len;
        for (int i = 0; i < len; i++) begin
            // occasional stray empty mark, sometimes mid edge
            if ($urandom_range(0, 39) == 0)
                send(8'($urandom()), 16'($urandom()), 1'($urandom()), 1'b1);
            send(rand_class(), rand_prob(), i == len - 1, 1'b0);
        end
    endtask

    initial begin
        int n;
        int count;
        logic [23:0] res_set[6];
        logic [16:0] frac_set[6];
        res_set = '{24'd65536, 24'd1, 24'hFFFFFF, 24'd0, 24'd13107, 24'd200000};
        frac_set = '{17'd32768, 17'd0, 17'd65536, 17'h1FFFF, 17'd1, 17'd50000};
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MAP_RES;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_terrain_class = '0;
        s_prob = '0;
        s_last_sample = 1'b0;
        s_empty_edge = 1'b0;
        hold_req = 1'b0;
        no_gaps = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed edges at reset settings
        send(FORBIDDEN_CLASS, 16'hFFFF, 1'b0, 1'b1);
        send(8'd0, 16'hFFFF, 1'b0, 1'b0);
        send(8'd1, 16'd7, 1'b0, 1'b0);
        send(8'd3, 16'd6, 1'b0, 1'b0);
        send(8'd4, 16'd1, 1'b1, 1'b0);
        send(8'd0, 16'd0, 1'b1, 1'b0);                 // no valid sample
        send(OFFMAP_CLASS, 16'd100, 1'b0, 1'b0);
        send(OFFMAP_CLASS, 16'd0, 1'b0, 1'b0);
        send(8'd5, 16'd200, 1'b1, 1'b0);               // too far off map
        send(8'd10, 16'd300, 1'b0, 1'b0);
        send(FORBIDDEN_CLASS, 16'd400, 1'b0, 1'b0);
        send(8'd9, 16'd500, 1'b1, 1'b0);               // aborted edge
        send(OFFMAP_CLASS, 16'hFFFF, 1'b0, 1'b0);
        send(8'd0, 16'h8000, 1'b1, 1'b0);              // off map exactly at limit
        send(FORBIDDEN_CLASS, 16'd0, 1'b1, 1'b0);
        send(8'd7, 16'd1000, 1'b0, 1'b0);
        send(8'd7, 16'd1000, 1'b1, 1'b1);              // empty mark drops state
        send(8'd128, 16'd255, 1'b1, 1'b0);
        send(8'd254, 16'h5555, 1'b1, 1'b0);

        count = 0;
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            write_reg(REG_MAP_RES, res_set[ph]);
            write_reg(REG_MAX_FRAC, 24'(frac_set[ph]));
            send(8'd0, 16'd0, 1'b1, 1'b0);
            send(8'd0, 16'd9000, 1'b1, 1'b0);
            if (ph == 1) begin
                // block fills up while the receiver holds off
                no_gaps = 1'b1;
                hold_req <= 1'b1;
                @(posedge aclk);
                hold_req <= 1'b0;
                for (int e = 0; e < 12; e++) send(8'd0, 16'd0, 1'b1, 1'b0);
                no_gaps = 1'b0;
            end
            while (count < (ph + 1) * 275) begin
                rand_edge(n);
                count += n;
            end
        end
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("edge_neg_log_prob_cost_top: match");
        end else begin
            $display("edge_neg_log_prob_cost_top: mismatch");
        end
        $finish;
    end

endmodule
